>>> rtl/u8v_pkg.sv
// ----------------------------------------------------------------------------
// u8v_pkg
// Shared constants and types for the UTF-8 stream validator.
// ----------------------------------------------------------------------------
package u8v_pkg;

    // Longest text that is checked; later bytes only raise the too-long flag
    localparam int unsigned MAX_TEXT_BYTES = 65536;
    localparam int unsigned CNT_W  = $clog2(MAX_TEXT_BYTES + 1);
    localparam int unsigned POS_W  = $clog2(MAX_TEXT_BYTES);
    localparam int unsigned BASE_W = 32;
    localparam int unsigned OFS_W  = BASE_W + 1;

    // Stream widths
    localparam int unsigned IN_DATA_W  = 40;   // text_byte + base_offset
    localparam int unsigned OUT_DATA_W = 40;   // status + error_offset, zero padded
    localparam int unsigned OUT_PAD_W  = OUT_DATA_W - 2 - OFS_W;

    // Result status codes
    localparam logic [1:0] ST_VALID    = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    // Lead bytes with a tighter second-byte range
    localparam logic [2:0] LEAD_NONE = 3'd0;
    localparam logic [2:0] LEAD_E0   = 3'd1;
    localparam logic [2:0] LEAD_ED   = 3'd2;
    localparam logic [2:0] LEAD_F0   = 3'd3;
    localparam logic [2:0] LEAD_F4   = 3'd4;

    // Per-text decoder state
    typedef struct packed {
        logic              in_text;
        logic [CNT_W-1:0]  byte_count;
        logic [BASE_W-1:0] saved_base;
        logic [1:0]        cont_left;
        logic              second_due;
        logic [2:0]        lead_kind;
        logic [POS_W-1:0]  lead_pos;
        logic              tent_err;
        logic [POS_W-1:0]  tent_pos;
        logic              final_err;
        logic [POS_W-1:0]  final_pos;
        logic              too_long;
    } text_state_t;

    localparam text_state_t TEXT_STATE_CLEAR = '0;

endpackage

>>> rtl/utf8_stream_validator_unit.sv
// ----------------------------------------------------------------------------
// utf8_stream_validator_unit
// Strict UTF-8 checker for a byte stream, one result per text.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_axis_*: one text byte per transaction. tlast marks the
//   last byte of a text, tuser marks an empty text (the byte is ignored).
//   base_offset travels in tdata and is taken from a text's first byte.
//   Output channel m_axis_*: one transaction per text, carrying status
//   (valid / invalid / too long) and the error offset (base + byte index).
//   Throughput: one byte per cycle, set by the single-pass decode between
//   the input register and the result register, while no result waits on m_axis_tready.
//   Result path: once its last byte is accepted, a text's result is decoded out
//   of the input register into the result register, which drives m_axis.
//   Stall: while a result waits on m_axis_tready, bytes that produce no
//   result keep flowing; a byte that ends a text waits in the input
//   register until the result register frees up.
//   Reset: rst_n clears both channels and the text state; no text is open.
// ----------------------------------------------------------------------------
module utf8_stream_validator_unit
    import u8v_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // tdata: [7:0] text_byte, [39:8] base_offset
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: [0] text_empty
    input  logic                  s_axis_tuser,
    input  logic                  s_axis_tlast,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: [1:0] status, [34:2] error_offset, [39:35] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready
);

    // Input register
    logic              in_valid_reg;
    logic [7:0]        byte_reg;
    logic              last_reg;
    logic              empty_reg;
    logic [BASE_W-1:0] base_reg;

    // Result register
    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic [OFS_W-1:0]  offset_reg;
    logic [1:0]        status_next;
    logic [OFS_W-1:0]  offset_next;

    // Text state
    text_state_t       state_reg;
    text_state_t       state_next;
    text_state_t       work;

    logic              has_result;
    logic              advance;
    logic              byte_ok;
    logic [POS_W-1:0]  pos;

    // Handshake: a transaction that gives no result never waits on the output
    assign has_result    = empty_reg | last_reg;
    assign advance       = in_valid_reg & (~has_result | ~out_valid_reg | m_axis_tready);
    assign s_axis_tready = ~in_valid_reg | advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            byte_reg  <= s_axis_tdata[7:0];
            base_reg  <= s_axis_tdata[8 +: BASE_W];
            last_reg  <= s_axis_tlast;
            empty_reg <= s_axis_tuser;
        end
    end

    // Decode one byte against the text state
    always_comb
    begin
        work        = state_reg;
        byte_ok     = 1'b1;
        status_next = ST_VALID;
        offset_next = '0;
        pos         = state_reg.byte_count[POS_W-1:0];

        // First byte of a text opens a fresh state
        if (!state_reg.in_text)
        begin
            work            = TEXT_STATE_CLEAR;
            work.in_text    = 1'b1;
            work.saved_base = base_reg;
            pos             = '0;
        end

        if (work.byte_count < CNT_W'(MAX_TEXT_BYTES))
        begin
            work.byte_count = work.byte_count + CNT_W'(1);
            if (!work.final_err)
            begin
                if (work.cont_left != 2'd0)
                begin
                    // Continuation byte
                    if (!work.tent_err)
                    begin
                        byte_ok = (byte_reg inside {[8'h80:8'hBF]});
                        if (byte_ok && work.second_due)
                        begin
                            case (work.lead_kind)
                                LEAD_E0: byte_ok = (byte_reg >= 8'hA0);
                                LEAD_ED: byte_ok = (byte_reg <= 8'h9F);
                                LEAD_F0: byte_ok = (byte_reg >= 8'h90);
                                LEAD_F4: byte_ok = (byte_reg <= 8'h8F);
                                default: byte_ok = 1'b1;
                            endcase
                        end
                        if (!byte_ok)
                        begin
                            work.tent_err = 1'b1;
                            work.tent_pos = pos;
                        end
                    end
                    work.second_due = 1'b0;
                    work.cont_left  = work.cont_left - 2'd1;
                    // Sequence done: a held error becomes final
                    if (work.cont_left == 2'd0 && work.tent_err)
                    begin
                        work.final_err = 1'b1;
                        work.final_pos = work.tent_pos;
                        work.tent_err  = 1'b0;
                    end
                end
                else if (byte_reg > 8'h7F)
                begin
                    // Lead byte
                    if (byte_reg inside {[8'hC2:8'hDF]})
                    begin
                        work.cont_left = 2'd1;
                    end
                    else if (byte_reg inside {[8'hE0:8'hEF]})
                    begin
                        work.cont_left = 2'd2;
                    end
                    else if (byte_reg inside {[8'hF0:8'hF4]})
                    begin
                        work.cont_left = 2'd3;
                    end
                    else
                    begin
                        byte_ok = 1'b0;
                    end

                    if (byte_ok)
                    begin
                        case (byte_reg)
                            8'hE0:   work.lead_kind = LEAD_E0;
                            8'hED:   work.lead_kind = LEAD_ED;
                            8'hF0:   work.lead_kind = LEAD_F0;
                            8'hF4:   work.lead_kind = LEAD_F4;
                            default: work.lead_kind = LEAD_NONE;
                        endcase
                        work.lead_pos   = pos;
                        work.second_due = 1'b1;
                    end
                    else
                    begin
                        work.final_err = 1'b1;
                        work.final_pos = pos;
                    end
                end
            end
        end
        else
        begin
            work.too_long = 1'b1;
        end

        // Result for the last byte; too long wins, then final, then truncation
        if (work.too_long)
        begin
            status_next = ST_TOO_LONG;
            offset_next = {1'b0, work.saved_base};
        end
        else if (work.final_err)
        begin
            status_next = ST_INVALID;
            offset_next = {1'b0, work.saved_base} + OFS_W'(work.final_pos);
        end
        else if (work.cont_left != 2'd0)
        begin
            status_next = ST_INVALID;
            offset_next = {1'b0, work.saved_base} + OFS_W'(work.lead_pos);
        end

        state_next = work;
        if (empty_reg)
        begin
            state_next  = TEXT_STATE_CLEAR;
            status_next = ST_VALID;
            offset_next = '0;
        end
        else if (last_reg)
        begin
            state_next = TEXT_STATE_CLEAR;
        end
    end

    // Text state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= TEXT_STATE_CLEAR;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
        begin
            status_reg <= status_next;
            offset_reg <= offset_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, offset_reg, status_reg};

endmodule
